### rtl/core/tspf_pkg.sv
// ----------------------------------------------------------------------------
// tspf_pkg
// Shared types and constants of the tire sensor packet filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tspf_pkg;

  localparam int TAIL_BYTES      = 12;
  localparam int MAC_BYTES       = 6;
  localparam int MAC_W           = 8 * MAC_BYTES;
  localparam int CNT_W           = $clog2(TAIL_BYTES + 1);
  localparam int HEX_LETTER_BASE = 10;
  localparam int AGE_BITS_DEF    = 32;
  localparam int OFFSET_W        = 16;
  localparam int TIMEOUT_W       = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MAC_W;

  localparam int OUT_DATA_W = 136;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEX_TEXT_MODE = 3'd0,
    CFG_MAC_FIXED     = 3'd1,
    CFG_FIXED_MAC     = 3'd2,
    CFG_KPA_OFFSET    = 3'd3,
    CFG_STALE_TIMEOUT = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_ELEMENT = 1'b0,
    OP_TICK    = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                 mac_fixed;
    logic [MAC_W-1:0]     fixed_mac;
    logic [OFFSET_W-1:0]  kpa_offset;
    logic [TIMEOUT_W-1:0] stale_timeout;
  } cfg_t;

  // Packet view after the current element has been taken in
  typedef struct packed {
    logic             tick;
    logic             pkt_end;
    logic             full;
    logic [7:0]       voltage;
    logic [7:0]       temperature;
    logic [15:0]      pressure;
    logic [MAC_W-1:0] mac;
  } pkt_view_t;

  typedef struct packed {
    logic             event_kind;
    logic             accepted;
    logic [7:0]       voltage_raw;
    logic [7:0]       temperature_raw;
    logic [15:0]      pressure_raw;
    logic [15:0]      pressure_kpa;
    logic [MAC_W-1:0] sensor_mac;
    logic             readings_valid;
    logic [31:0]      age_ms;
    logic             stale;
  } result_t;

  // Bit 4 set means not a hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'(HEX_LETTER_BASE));
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'(HEX_LETTER_BASE));
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tspf_assembler.sv
// ----------------------------------------------------------------------------
// tspf_assembler
// Byte assembly from raw or hex text elements and the tail window.
// ----------------------------------------------------------------------------
`default_nettype none

module tspf_assembler (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic                tick,
  input  wire logic [7:0]          element,
  input  wire logic                last,
  input  wire logic                hex_mode,
  output tspf_pkg::pkt_view_t      view
);
  import tspf_pkg::*;

  logic [7:0]       win_r   [TAIL_BYTES];
  logic [7:0]       win_nxt [TAIL_BYTES];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_new;
  logic [3:0]       held_r, held_nxt;
  logic             pend_r, pend_nxt;
  logic [4:0]       nib;
  logic             push;
  logic [7:0]       push_byte;

  always_comb begin
    nib       = hex_nibble(element);
    push      = 1'b0;
    push_byte = element;
    held_nxt  = held_r;
    pend_nxt  = pend_r;
    if (!tick) begin
      if (hex_mode) begin
        if (!nib[4]) begin
          if (pend_r) begin
            push      = 1'b1;
            push_byte = {held_r, nib[3:0]};
            pend_nxt  = 1'b0;
            held_nxt  = '0;
          end else begin
            held_nxt = nib[3:0];
            pend_nxt = 1'b1;
          end
        end
      end else begin
        push = 1'b1;
      end
    end

    for (int i = 0; i < TAIL_BYTES - 1; i++) begin
      win_nxt[i] = push ? win_r[i+1] : win_r[i];
    end
    win_nxt[TAIL_BYTES-1] = push ? push_byte : win_r[TAIL_BYTES-1];

    cnt_new = (push && cnt_r != CNT_W'(TAIL_BYTES)) ? cnt_r + 1'b1 : cnt_r;
    cnt_nxt = cnt_new;
    if (!tick && last) begin
      cnt_nxt  = '0;
      pend_nxt = 1'b0;
      held_nxt = '0;
    end
  end

  always_comb begin
    view.tick        = tick;
    view.pkt_end     = !tick && last;
    view.full        = (cnt_new == CNT_W'(TAIL_BYTES));
    view.voltage     = win_nxt[0];
    view.temperature = win_nxt[1];
    view.pressure    = {win_nxt[2], win_nxt[3]};
    for (int i = 0; i < MAC_BYTES; i++) begin
      view.mac[8*(MAC_BYTES-1-i) +: 8] = win_nxt[TAIL_BYTES-MAC_BYTES+i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      held_r <= '0;
      pend_r <= 1'b0;
    end else if (go) begin
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tspf_tracker.sv
// ----------------------------------------------------------------------------
// tspf_tracker
// Packet judgement, latched readings, learned address and reading age.
// ----------------------------------------------------------------------------
`default_nettype none

module tspf_tracker #(
  parameter int AGE_BITS = tspf_pkg::AGE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire tspf_pkg::pkt_view_t view,
  input  wire tspf_pkg::cfg_t      cfg,
  output logic                     res_en,
  output tspf_pkg::result_t        result
);
  import tspf_pkg::*;

  logic [7:0]          volt_r, volt_nxt;
  logic [7:0]          temp_r, temp_nxt;
  logic [15:0]         pres_r, pres_nxt;
  logic [MAC_W-1:0]    mac_r, mac_nxt;
  logic                have_r, have_nxt;
  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic                hit;
  logic [AGE_BITS+31:0] age_ext, tmo_ext;

  always_comb begin
    hit = view.pkt_end && view.full &&
          (cfg.mac_fixed ? (view.mac == cfg.fixed_mac)
                         : (!have_r || view.mac == mac_r));
    volt_nxt = volt_r;
    temp_nxt = temp_r;
    pres_nxt = pres_r;
    mac_nxt  = mac_r;
    have_nxt = have_r;
    age_nxt  = age_r;
    if (view.tick) begin
      if (have_r && age_r != '1) begin
        age_nxt = age_r + 1'b1;
      end
    end else if (hit) begin
      volt_nxt = view.voltage;
      temp_nxt = view.temperature;
      pres_nxt = view.pressure;
      if (!cfg.mac_fixed) begin
        mac_nxt = view.mac;
      end
      have_nxt = 1'b1;
      age_nxt  = '0;
    end
  end

  always_comb begin
    age_ext = {32'b0, age_nxt};
    tmo_ext = {{AGE_BITS{1'b0}}, cfg.stale_timeout};
    res_en  = view.tick || view.pkt_end;
    result.event_kind      = view.tick;
    result.accepted        = hit;
    result.voltage_raw     = volt_nxt;
    result.temperature_raw = temp_nxt;
    result.pressure_raw    = pres_nxt;
    result.pressure_kpa    = (pres_nxt > cfg.kpa_offset) ?
                             pres_nxt - cfg.kpa_offset : '0;
    result.sensor_mac      = cfg.mac_fixed ? cfg.fixed_mac : mac_nxt;
    result.readings_valid  = have_nxt;
    result.age_ms          = age_ext[31:0];
    result.stale           = !have_nxt || (age_ext > tmo_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r <= '0;
      temp_r <= '0;
      pres_r <= '0;
      mac_r  <= '0;
      have_r <= 1'b0;
      age_r  <= '1;
    end else if (go) begin
      volt_r <= volt_nxt;
      temp_r <= temp_nxt;
      pres_r <= pres_nxt;
      mac_r  <= mac_nxt;
      have_r <= have_nxt;
      age_r  <= age_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tire_sensor_packet_filter.sv
// ----------------------------------------------------------------------------
// tire_sensor_packet_filter
// Filters tire sensor advertisements and tracks the latest accepted reading.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packet element or one millisecond tick per transfer. tuser is
//           the opcode (1 = tick), tdata the element, tlast ends a packet.
//   out_* : one result per tick and per packet end; tuser is the event kind.
//   cfg_* : register writes, index 0..4; cfg_ready is always high. Write
//           only while the block holds no item and no undelivered result.
// Timing: an input transfer is registered in the input register, processed
//   from there and its result is registered into the out_* result register.
// Throughput: one input transfer per cycle while out_tready is high; the
//   update of the packet and reading state sets this figure.
// Reset: registers that have a reset return to their reset values, the age
//   reads all ones and nothing is valid on either channel.
// Stall: with out_tready low a waiting result holds, at most one further
//   input transfer is taken into the input register, then in_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module tire_sensor_packet_filter #(
  parameter int AGE_BITS = tspf_pkg::AGE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] element
  input  wire logic                            in_tuser,   // [0] opcode
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] accepted, [8:1] voltage_raw, [16:9] temperature_raw,
  // [32:17] pressure_raw, [48:33] pressure_kpa, [96:49] sensor_mac,
  // [97] readings_valid, [129:98] age_ms, [130] stale, [135:131] zero
  output logic [tspf_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tuser,  // [0] event_kind
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tspf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tspf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tspf_pkg::*;

  logic       hex_mode_r;
  cfg_t       cfg_r;

  logic       in_vld_r;
  logic       op_r;
  logic [7:0] elem_r;
  logic       last_r;
  logic       proc_go;

  pkt_view_t  view;
  logic       res_en;
  result_t    result;
  result_t    res_r;
  logic       out_vld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r          <= 1'b0;
      cfg_r.mac_fixed     <= 1'b0;
      cfg_r.fixed_mac     <= '0;
      cfg_r.kpa_offset    <= '0;
      cfg_r.stale_timeout <= TIMEOUT_W'(30000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        CFG_HEX_TEXT_MODE: hex_mode_r          <= cfg_data[0];
        CFG_MAC_FIXED:     cfg_r.mac_fixed     <= cfg_data[0];
        CFG_FIXED_MAC:     cfg_r.fixed_mac     <= cfg_data[MAC_W-1:0];
        CFG_KPA_OFFSET:    cfg_r.kpa_offset    <= cfg_data[OFFSET_W-1:0];
        CFG_STALE_TIMEOUT: cfg_r.stale_timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign proc_go   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      elem_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  tspf_assembler u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (proc_go),
    .tick     (op_r == OP_TICK),
    .element  (elem_r),
    .last     (last_r),
    .hex_mode (hex_mode_r),
    .view     (view)
  );

  tspf_tracker #(
    .AGE_BITS (AGE_BITS)
  ) u_trk (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (proc_go),
    .view   (view),
    .cfg    (cfg_r),
    .res_en (res_en),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && res_en) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_en) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.event_kind;
  assign out_tdata  = {5'b0, res_r.stale, res_r.age_ms, res_r.readings_valid,
                       res_r.sensor_mac, res_r.pressure_kpa, res_r.pressure_raw,
                       res_r.temperature_raw, res_r.voltage_raw, res_r.accepted};

  // An accepted packet always reports a fresh, valid reading
  a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.accepted |-> res_r.readings_valid && res_r.age_ms == '0)
    else $error("accepted packet without fresh reading");

  a_invalid_stale: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.readings_valid |-> res_r.stale)
    else $error("reading reported current before any acceptance");

  a_tick_not_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.event_kind |-> !res_r.accepted)
    else $error("tick result flagged as accepted");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc_go |=> in_vld_r && $stable(elem_r) && $stable(op_r))
    else $error("pending item lost while output stalled");

endmodule

`default_nettype wire
